// ----- hw/rtl/pfc_pkg.sv -----
// Shared types, letter codes and key-square helpers for the Playfair digraph cipher core.
// No dependencies; every other file of the core imports this package.
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int SqDim   = 5;
    localparam int LetterW = 5;
    localparam int PosW    = 3;
    localparam int CfgIdxW = 3;
    localparam int RowW    = SqDim * LetterW;

    localparam logic [LetterW-1:0] LETTER_I = 5'd8;
    localparam logic [LetterW-1:0] LETTER_J = 5'd9;
    localparam logic [LetterW-1:0] LETTER_X = 5'd23;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DIRECTION = 3'd0,
        CFG_ROW0      = 3'd1,
        CFG_ROW1      = 3'd2,
        CFG_ROW2      = 3'd3,
        CFG_ROW3      = 3'd4,
        CFG_ROW4      = 3'd5
    } t_cfg_idx;

    // Key square: [row][col][bit], column 0 in the lowest bits of each row.
    typedef logic [SqDim-1:0][SqDim-1:0][LetterW-1:0] t_square;

    typedef struct packed {
        logic [PosW-1:0] row;
        logic [PosW-1:0] col;
    } t_pos;

    // One digraph waiting for transformation.
    typedef struct packed {
        logic [LetterW-1:0] first;
        logic [LetterW-1:0] second;
        logic               twice;   // emit the digraph two times (doubled final letter)
    } t_job;

    // First occurrence of a code in row-major order; row 0 column 0 when absent.
    function automatic t_pos locate(input t_square sq, input logic [LetterW-1:0] code);
        t_pos pos;
        pos = '0;
        for (int r = SqDim - 1; r >= 0; r--) begin
            for (int c = SqDim - 1; c >= 0; c--) begin
                if (sq[r][c] == code) begin
                    pos.row = PosW'(r);
                    pos.col = PosW'(c);
                end
            end
        end
        return pos;
    endfunction

    // Moves a row or column position one place forward, or back when dec is set.
    function automatic logic [PosW-1:0] step_pos(input logic [PosW-1:0] v, input logic dec);
        logic [PosW-1:0] res;
        if (dec) begin
            res = (v == '0) ? PosW'(SqDim - 1) : v - 1'b1;
        end else begin
            res = (v == PosW'(SqDim - 1)) ? '0 : v + 1'b1;
        end
        return res;
    endfunction

endpackage

// ----- hw/rtl/pfc_pair_former.sv -----
// Digraph former: normalizes J to I, holds the odd letter and registers one digraph job.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_pair_former import pfc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [LetterW-1:0] i_letter,
    input  logic               i_final,
    output logic               o_job_valid,
    output t_job               o_job,
    input  logic               i_take
);

    logic               r_held_valid, n_held_valid;
    logic [LetterW-1:0] r_held_letter, n_held_letter;
    logic               r_job_valid;
    t_job               r_job, n_job;
    logic               n_has_job;
    logic [LetterW-1:0] letter;
    logic               accept;

    assign o_ready     = !r_job_valid || i_take;
    assign accept      = i_valid && o_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign letter      = (i_letter == LETTER_J) ? LETTER_I : i_letter;

    always_comb begin
        n_held_valid  = r_held_valid;
        n_held_letter = r_held_letter;
        n_has_job     = 1'b0;
        n_job         = r_job;
        if (!r_held_valid) begin
            if (i_final) begin
                n_has_job = 1'b1;
                n_job     = '{first: letter, second: LETTER_X, twice: 1'b0};
            end else begin
                n_held_valid  = 1'b1;
                n_held_letter = letter;
            end
        end else if (r_held_letter != letter) begin
            n_has_job     = 1'b1;
            n_job         = '{first: r_held_letter, second: letter, twice: 1'b0};
            n_held_valid  = 1'b0;
            n_held_letter = '0;
        end else begin
            // Doubled letter: pair with X; a final one is paired with X again.
            n_has_job = 1'b1;
            n_job     = '{first: r_held_letter, second: LETTER_X, twice: i_final};
            if (i_final) begin
                n_held_valid  = 1'b0;
                n_held_letter = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid  <= 1'b0;
            r_held_letter <= '0;
            r_job_valid   <= 1'b0;
        end else if (accept) begin
            r_held_valid  <= n_held_valid;
            r_held_letter <= n_held_letter;
            r_job_valid   <= n_has_job;
        end else if (i_take) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_has_job) begin
            r_job <= n_job;
        end
    end

endmodule

// ----- hw/rtl/pfc_transform.sv -----
// Key-square lookup and Playfair row, column or rectangle rule for one digraph.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_transform import pfc_pkg::*; (
    input  t_square            i_square,
    input  logic               i_decrypt,
    input  logic [LetterW-1:0] i_first,
    input  logic [LetterW-1:0] i_second,
    output logic [LetterW-1:0] o_first,
    output logic [LetterW-1:0] o_second
);

    t_pos pa, pb;

    assign pa = locate(i_square, i_first);
    assign pb = locate(i_square, i_second);

    always_comb begin
        if (pa.row == pb.row) begin
            // Same row, which also covers two equal letters.
            o_first  = i_square[pa.row][step_pos(pa.col, i_decrypt)];
            o_second = i_square[pb.row][step_pos(pb.col, i_decrypt)];
        end else if (pa.col == pb.col) begin
            o_first  = i_square[step_pos(pa.row, i_decrypt)][pa.col];
            o_second = i_square[step_pos(pb.row, i_decrypt)][pb.col];
        end else begin
            o_first  = i_square[pa.row][pb.col];
            o_second = i_square[pb.row][pa.col];
        end
    end

endmodule

// ----- hw/rtl/playfair_digraph_cipher_core.sv -----
// Top level of the Playfair digraph cipher core: configuration registers, digraph former,
// transform and the output beat buffer. Depends on pfc_pkg, pfc_pair_former, pfc_transform.
`timescale 1ns / 1ps

// The core takes one message letter per input beat (A=0 through Z=25, tlast on the last
// letter of a message) and emits the enciphered or deciphered letters one per output beat,
// tlast marking the last letter caused by an input beat. J is folded into I, a doubled
// letter is paired with X and an odd final letter is padded with X. A letter that only
// opens a digraph yields no output; a closing letter yields two beats, and a doubled final
// letter yields four. An input beat is taken every cycle while the digraph register is
// free, so the sustained rate is set by the output port, which sends one letter per output
// beat, while the next digraph waits in the digraph register. An input beat's digraph is
// registered there and then in the output buffer. The key square and the direction are
// written through the configuration port (index 0 direction, 1 through 5 square rows,
// other indexes ignored) and must only be changed while no message is in flight.

module playfair_digraph_cipher_core import pfc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CfgIdxW-1:0]   i_cfg_index,
    input  logic [RowW-1:0]      i_cfg_data,
    // Letter input stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [4:0] in_letter, [7:5] zero
    input  logic                 s_axis_tlast,   // in_final
    // Letter output stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [4:0] out_letter, [7:5] zero
    output logic                 m_axis_tlast    // run_end
);

    // Configuration registers.
    logic    r_decrypt;
    t_square r_square;

    // Digraph job between the former and the output buffer.
    logic               job_valid;
    t_job               job;
    logic               job_take;
    logic [LetterW-1:0] tr_first, tr_second;

    // Output buffer: the transformed digraph and the beats still to send (0, 1..4).
    logic [2:0]         r_left;
    logic [LetterW-1:0] r_out_first, r_out_second;
    logic               out_beat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_square  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIRECTION: r_decrypt   <= i_cfg_data[0];
                CFG_ROW0:      r_square[0] <= i_cfg_data;
                CFG_ROW1:      r_square[1] <= i_cfg_data;
                CFG_ROW2:      r_square[2] <= i_cfg_data;
                CFG_ROW3:      r_square[3] <= i_cfg_data;
                CFG_ROW4:      r_square[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pfc_pair_former u_former (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_letter    (s_axis_tdata[LetterW-1:0]),
        .i_final     (s_axis_tlast),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_take      (job_take)
    );

    pfc_transform u_transform (
        .i_square  (r_square),
        .i_decrypt (r_decrypt),
        .i_first   (job.first),
        .i_second  (job.second),
        .o_first   (tr_first),
        .o_second  (tr_second)
    );

    // The buffer reloads once it is empty or its last beat leaves this cycle.
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign job_take = job_valid && ((r_left == 3'd0) || ((r_left == 3'd1) && m_axis_tready));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (job_take) begin
            r_left <= job.twice ? 3'd4 : 3'd2;
        end else if (out_beat) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_take) begin
            r_out_first  <= tr_first;
            r_out_second <= tr_second;
        end
    end

    // An odd count of beats left means the second letter of the digraph is due.
    assign m_axis_tvalid = (r_left != 3'd0);
    assign m_axis_tdata  = {3'b000, r_left[0] ? r_out_second : r_out_first};
    assign m_axis_tlast  = (r_left == 3'd1);

    // A fresh digraph always leaves two or four beats to send.
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take |=> (r_left == 3'd2) || (r_left == 3'd4))
        else $error("output buffer loaded with a wrong beat count");

    // After the closing beat the buffer is either empty or holds a new digraph.
    a_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && m_axis_tlast) |=> (r_left == 3'd0) || (r_left == 3'd2) || (r_left == 3'd4))
        else $error("beats left over after a closing beat");

    // J never reaches the key-square lookup.
    a_no_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_valid |-> (job.first != LETTER_J) && (job.second != LETTER_J))
        else $error("letter J in a digraph job");

    // A waiting job is never dropped: it stays until the buffer takes it.
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (job_valid && !job_take) |=> job_valid && $stable(job))
        else $error("digraph job lost before transformation");

endmodule
